// ===== rtl/fsrs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Failsafe response selector package
// Types, codes and reset values shared by the selector and its checker.
// ----------------------------------------------------------------------------
package fsrs_pkg;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 24;
  localparam int unsigned ThrWidth      = 10;
  localparam int unsigned DistWidth     = 24;
  localparam int unsigned AgeWidth      = 32;
  localparam int unsigned TimeoutWidth  = 16;

  typedef enum logic [1:0] {
    OP_RADIO_LOST  = 2'd0,
    OP_RADIO_BACK  = 2'd1,
    OP_BATTERY_LOW = 2'd2,
    OP_GPS_CHECK   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    MODE_STABILIZE = 3'd0,
    MODE_ACRO      = 3'd1,
    MODE_SPORT     = 3'd2,
    MODE_AUTO      = 3'd3,
    MODE_LOITER    = 3'd4,
    MODE_ALT_HOLD  = 3'd5,
    MODE_LAND      = 3'd6,
    MODE_OTHER     = 3'd7
  } mode_e;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_DISARM  = 3'd1,
    ACT_RTL     = 3'd2,
    ACT_LAND    = 3'd3,
    ACT_ALTHOLD = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_RADIO_LOST = 3'd1,
    EV_RADIO_BACK = 3'd2,
    EV_BATTERY    = 3'd3,
    EV_GPS        = 3'd4
  } event_e;

  typedef enum logic [CfgIndexWidth-1:0] {
    REG_THROTTLE_FS = 3'd0,
    REG_BATTERY_FS  = 3'd1,
    REG_GPS_FS      = 3'd2,
    REG_GPS_TIMEOUT = 3'd3,
    REG_WP_RADIUS   = 3'd4
  } reg_e;

  // Radio failsafe policy codes.
  localparam logic [1:0] ThrFsDisabled = 2'd0;
  localparam logic [1:0] ThrFsRtl      = 2'd1;
  localparam logic [1:0] ThrFsContinue = 2'd2;
  localparam logic [1:0] ThrFsLand     = 2'd3;

  // Battery failsafe policy codes.
  localparam logic [1:0] BattFsDisabled = 2'd0;
  localparam logic [1:0] BattFsLand     = 2'd1;
  localparam logic [1:0] BattFsRtl      = 2'd2;

  // GPS failsafe policy codes.
  localparam logic [1:0] GpsFsDisabled = 2'd0;
  localparam logic [1:0] GpsFsLand     = 2'd1;
  localparam logic [1:0] GpsFsAltHold  = 2'd2;

  localparam logic [1:0]              ThrFsReset    = ThrFsRtl;
  localparam logic [1:0]              BattFsReset   = BattFsLand;
  localparam logic [1:0]              GpsFsReset    = GpsFsLand;
  localparam logic [TimeoutWidth-1:0] GpsTimeoutRst = 16'd5000;
  localparam logic [DistWidth-1:0]    WpRadiusRst   = 24'd200;

  typedef struct packed {
    op_e                  operation;
    mode_e                flight_mode;
    logic                 motors_armed;
    logic [ThrWidth-1:0]  throttle_in;
    logic                 touchdown;
    logic [DistWidth-1:0] home_distance_cm;
    logic                 rtl_allowed;
    logic                 home_set;
    logic [AgeWidth-1:0]  gps_age_ms;
    logic                 radio_failsafe;
  } item_t;

  typedef struct packed {
    action_e action;
    event_e  log_event;
    logic    battery_fs_flag;
    logic    gps_fs_flag;
  } result_t;

endpackage

// ===== rtl/failsafe_response_selector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Failsafe response selector
// Picks the failsafe action and log event for each event beat and keeps the
// latched battery and GPS failsafe flags.
// ----------------------------------------------------------------------------
// Channel  | Handshake             | Beat contents
// ---------+-----------------------+------------------------------------------
// in       | in_valid_i/in_ready_o | operation_i ... radio_failsafe_i
// out      | out_valid_o/out_ready_i | action_o, log_event_o, flag outputs
// cfg      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One beat is accepted per cycle while in_ready_o is high; the beat is held in the
// item register and its result then loads into the result register, from which
// it can be taken once out_valid_o is high.
// When out_ready_i is low both registers fill and in_ready_o then drops.
// Reset clears both latches, the valid flags and loads the default policies.
// Configuration writes are always taken.
// ----------------------------------------------------------------------------
module failsafe_response_selector (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [fsrs_pkg::CfgIndexWidth-1:0]  cfg_index_i,
  input  logic [fsrs_pkg::CfgDataWidth-1:0]   cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          operation_i,
  input  logic [2:0]                          flight_mode_i,
  input  logic                                motors_armed_i,
  input  logic [fsrs_pkg::ThrWidth-1:0]       throttle_in_i,
  input  logic                                touchdown_i,
  input  logic [fsrs_pkg::DistWidth-1:0]      home_distance_cm_i,
  input  logic                                rtl_allowed_i,
  input  logic                                home_set_i,
  input  logic [fsrs_pkg::AgeWidth-1:0]       gps_age_ms_i,
  input  logic                                radio_failsafe_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [2:0]                          action_o,
  output logic [2:0]                          log_event_o,
  output logic                                battery_fs_flag_o,
  output logic                                gps_fs_flag_o
);

  logic [1:0]                          thr_fs_q;
  logic [1:0]                          batt_fs_q;
  logic [1:0]                          gps_fs_q;
  logic [fsrs_pkg::TimeoutWidth-1:0]   gps_timeout_q;
  logic [fsrs_pkg::DistWidth-1:0]      wp_radius_q;

  logic                                item_vld_q;
  fsrs_pkg::item_t                     item_q;
  fsrs_pkg::item_t                     item_d;
  logic                                res_vld_q;
  fsrs_pkg::result_t                   res_q;
  fsrs_pkg::result_t                   res_d;
  logic                                batt_latch_q;
  logic                                batt_latch_d;
  logic                                gps_latch_q;
  logic                                gps_latch_d;

  logic                                advance;
  logic                                in_fire;
  logic                                far;
  logic                                thr_zero;
  logic                                rtl_pol;
  fsrs_pkg::action_e                   home_or_land;
  fsrs_pkg::action_e                   radio_default;
  fsrs_pkg::action_e                   batt_home;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_fs_q      <= fsrs_pkg::ThrFsReset;
      batt_fs_q     <= fsrs_pkg::BattFsReset;
      gps_fs_q      <= fsrs_pkg::GpsFsReset;
      gps_timeout_q <= fsrs_pkg::GpsTimeoutRst;
      wp_radius_q   <= fsrs_pkg::WpRadiusRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        fsrs_pkg::REG_THROTTLE_FS: thr_fs_q      <= cfg_data_i[1:0];
        fsrs_pkg::REG_BATTERY_FS:  batt_fs_q     <= cfg_data_i[1:0];
        fsrs_pkg::REG_GPS_FS:      gps_fs_q      <= cfg_data_i[1:0];
        fsrs_pkg::REG_GPS_TIMEOUT: gps_timeout_q <= cfg_data_i[fsrs_pkg::TimeoutWidth-1:0];
        fsrs_pkg::REG_WP_RADIUS:   wp_radius_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign advance    = item_vld_q && (!res_vld_q || out_ready_i);
  assign in_ready_o = !item_vld_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    item_d.operation        = fsrs_pkg::op_e'(operation_i);
    item_d.flight_mode      = fsrs_pkg::mode_e'(flight_mode_i);
    item_d.motors_armed     = motors_armed_i;
    item_d.throttle_in      = throttle_in_i;
    item_d.touchdown        = touchdown_i;
    item_d.home_distance_cm = home_distance_cm_i;
    item_d.rtl_allowed      = rtl_allowed_i;
    item_d.home_set         = home_set_i;
    item_d.gps_age_ms       = gps_age_ms_i;
    item_d.radio_failsafe   = radio_failsafe_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      item_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= item_d;
    end
  end

  assign far      = item_q.home_distance_cm > wp_radius_q;
  assign thr_zero = item_q.throttle_in == '0;
  assign rtl_pol  = batt_fs_q == fsrs_pkg::BattFsRtl;

  assign home_or_land  = (far && item_q.rtl_allowed) ? fsrs_pkg::ACT_RTL : fsrs_pkg::ACT_LAND;
  assign radio_default = (thr_fs_q == fsrs_pkg::ThrFsLand) ? fsrs_pkg::ACT_LAND : home_or_land;
  assign batt_home     = (rtl_pol && far && item_q.rtl_allowed) ? fsrs_pkg::ACT_RTL
                                                                : fsrs_pkg::ACT_LAND;

  always_comb begin
    res_d.action    = fsrs_pkg::ACT_NONE;
    res_d.log_event = fsrs_pkg::EV_NONE;
    batt_latch_d    = batt_latch_q;
    gps_latch_d     = gps_latch_q;
    unique case (item_q.operation)
      fsrs_pkg::OP_RADIO_LOST: begin
        if (thr_fs_q != fsrs_pkg::ThrFsDisabled && item_q.motors_armed) begin
          res_d.log_event = fsrs_pkg::EV_RADIO_LOST;
          case (item_q.flight_mode) inside
            fsrs_pkg::MODE_STABILIZE, fsrs_pkg::MODE_ACRO, fsrs_pkg::MODE_SPORT: begin
              res_d.action = thr_zero ? fsrs_pkg::ACT_DISARM : radio_default;
            end
            fsrs_pkg::MODE_AUTO: begin
              if (thr_fs_q == fsrs_pkg::ThrFsRtl) begin
                res_d.action = home_or_land;
              end else if (thr_fs_q == fsrs_pkg::ThrFsLand) begin
                res_d.action = fsrs_pkg::ACT_LAND;
              end
            end
            fsrs_pkg::MODE_LOITER, fsrs_pkg::MODE_ALT_HOLD: begin
              res_d.action = (thr_zero && item_q.touchdown) ? fsrs_pkg::ACT_DISARM
                                                            : radio_default;
            end
            fsrs_pkg::MODE_LAND: begin
              if (!(batt_fs_q == fsrs_pkg::BattFsLand && batt_latch_q)) begin
                res_d.action = radio_default;
              end
            end
            default: begin
              res_d.action = radio_default;
            end
          endcase
        end
      end
      fsrs_pkg::OP_RADIO_BACK: begin
        res_d.log_event = fsrs_pkg::EV_RADIO_BACK;
      end
      fsrs_pkg::OP_BATTERY_LOW: begin
        if (!batt_latch_q) begin
          if (batt_fs_q != fsrs_pkg::BattFsDisabled && item_q.motors_armed) begin
            case (item_q.flight_mode) inside
              fsrs_pkg::MODE_STABILIZE, fsrs_pkg::MODE_ACRO, fsrs_pkg::MODE_SPORT: begin
                res_d.action = thr_zero ? fsrs_pkg::ACT_DISARM : batt_home;
              end
              fsrs_pkg::MODE_AUTO: begin
                res_d.action = home_or_land;
              end
              fsrs_pkg::MODE_LOITER, fsrs_pkg::MODE_ALT_HOLD: begin
                res_d.action = (thr_zero && item_q.touchdown) ? fsrs_pkg::ACT_DISARM
                                                              : batt_home;
              end
              default: begin
                res_d.action = batt_home;
              end
            endcase
          end
          batt_latch_d    = 1'b1;
          res_d.log_event = fsrs_pkg::EV_BATTERY;
        end
      end
      fsrs_pkg::OP_GPS_CHECK: begin
        if (gps_fs_q == fsrs_pkg::GpsFsDisabled || !item_q.home_set) begin
          gps_latch_d = 1'b0;
        end else if (item_q.gps_age_ms <
                     fsrs_pkg::AgeWidth'(gps_timeout_q)) begin
          gps_latch_d = 1'b0;
        end else if (!gps_latch_q && item_q.motors_armed) begin
          gps_latch_d     = 1'b1;
          res_d.log_event = fsrs_pkg::EV_GPS;
          res_d.action    = (gps_fs_q == fsrs_pkg::GpsFsAltHold && !item_q.radio_failsafe)
                            ? fsrs_pkg::ACT_ALTHOLD : fsrs_pkg::ACT_LAND;
        end
      end
      default: ;
    endcase
    res_d.battery_fs_flag = batt_latch_d;
    res_d.gps_fs_flag     = gps_latch_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      batt_latch_q <= 1'b0;
      gps_latch_q  <= 1'b0;
      res_vld_q    <= 1'b0;
    end else begin
      if (advance) begin
        batt_latch_q <= batt_latch_d;
        gps_latch_q  <= gps_latch_d;
      end
      if (advance) begin
        res_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o       = res_vld_q;
  assign action_o          = res_q.action;
  assign log_event_o       = res_q.log_event;
  assign battery_fs_flag_o = res_q.battery_fs_flag;
  assign gps_fs_flag_o     = res_q.gps_fs_flag;

endmodule

// ===== rtl/fsrs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Failsafe response selector checker
// Port-level assertions on result beats, bound to the selector.
// ----------------------------------------------------------------------------
module fsrs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [2:0] action_o,
  input logic [2:0] log_event_o,
  input logic       battery_fs_flag_o,
  input logic       gps_fs_flag_o
);

  // A stalled result beat holds its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(action_o)
      && $stable(log_event_o) && $stable(battery_fs_flag_o) && $stable(gps_fs_flag_o))
    else $error("stalled result beat changed");

  // A battery event always leaves the battery flag set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && log_event_o == fsrs_pkg::EV_BATTERY |-> battery_fs_flag_o)
    else $error("battery event without battery flag");

  // Altitude hold is only chosen by a fresh GPS failsafe.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_o == fsrs_pkg::ACT_ALTHOLD
      |-> log_event_o == fsrs_pkg::EV_GPS && gps_fs_flag_o)
    else $error("altitude hold without GPS failsafe");

  // Any action comes with a failsafe occurrence in the log.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_o != fsrs_pkg::ACT_NONE
      |-> log_event_o == fsrs_pkg::EV_RADIO_LOST || log_event_o == fsrs_pkg::EV_BATTERY
          || log_event_o == fsrs_pkg::EV_GPS)
    else $error("action without failsafe event");

  // A regained radio never triggers an action.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && log_event_o == fsrs_pkg::EV_RADIO_BACK |-> action_o == fsrs_pkg::ACT_NONE)
    else $error("action on radio regained");

endmodule

bind failsafe_response_selector fsrs_checker u_fsrs_checker (.*);
